/* src/lgf_pkg.sv */
// ----------------------------------------------------------------------------
// lgf_pkg: shared definitions for the lidar largest gap finder
// Field widths, register indexes, reset values and the tracker result type.
// ----------------------------------------------------------------------------
`default_nettype none

package lgf_pkg;

  // Fixed field widths.
  localparam int unsigned RANGE_W = 16;
  localparam int unsigned TOL_W   = 8;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned SIZE_W  = 12;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned REG_W   = 3;

  // Parameter defaults for the top level.
  localparam int unsigned MAX_BEAMS_DEF  = 2048;
  localparam int unsigned RANGE_BITS_DEF = 16;

  // Register reset values.
  localparam logic [RANGE_W-1:0] FAR_THR_RST  = 16'd1500;
  localparam logic [RANGE_W-1:0] NEAR_THR_RST = 16'd750;
  localparam logic [TOL_W-1:0]   TOL_RST      = 8'd8;
  localparam logic [IDX_W-1:0]   FIRST_RST    = 11'd180;
  localparam logic [IDX_W-1:0]   LAST_RST     = 11'd900;
  localparam logic [SIZE_W-1:0]  MIN_GAP_RST  = 12'd23;

  // Run sizes saturate at the top of the size field.
  localparam logic [SIZE_W-1:0]  SIZE_MAX = {SIZE_W{1'b1}};

  // Configuration register indexes.
  typedef enum logic [REG_W-1:0] {
    REG_FAR_THR  = 3'd0,
    REG_NEAR_THR = 3'd1,
    REG_ERR_TOL  = 3'd2,
    REG_FIRST    = 3'd3,
    REG_LAST     = 3'd4,
    REG_MIN_GAP  = 3'd5
  } reg_idx_e;

  // Best gap of one tracker.
  typedef struct packed {
    logic [IDX_W-1:0]  start;
    logic [SIZE_W-1:0] size;
  } best_t;

endpackage

`default_nettype wire

/* src/lgf_if.sv */
// ----------------------------------------------------------------------------
// lgf_if: valid/ready channels of the lidar largest gap finder
// Beam input channel, gap result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

// One beam sample per word.
interface lgf_beam_if;
  logic                         valid;
  logic                         ready;
  logic [lgf_pkg::RANGE_W-1:0]  range_mm;
  logic                         last_beam;

  modport source (output valid, output range_mm, output last_beam, input ready);
  modport sink   (input valid, input range_mm, input last_beam, output ready);
endinterface

// One gap result per scan.
interface lgf_gap_if;
  logic                        valid;
  logic                        ready;
  logic [lgf_pkg::IDX_W-1:0]   gap_start;
  logic [lgf_pkg::SIZE_W-1:0]  gap_size;
  logic                        used_near;
  logic                        gap_found;

  modport source (output valid, output gap_start, output gap_size, output used_near,
                  output gap_found, input ready);
  modport sink   (input valid, input gap_start, input gap_size, input used_near,
                  input gap_found, output ready);
endinterface

// Register writes.
interface lgf_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lgf_pkg::REG_W-1:0]  index;
  logic [lgf_pkg::CFG_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/lgf_tracker.sv */
// ----------------------------------------------------------------------------
// lgf_tracker: open-run tracker for one threshold
// Follows runs of open beams, bridges short blocked stretches and keeps the
// largest run. Reports the updated best gap in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lgf_tracker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        open_i,
  input  wire logic [lgf_pkg::IDX_W-1:0]   idx_i,
  input  wire logic [lgf_pkg::TOL_W-1:0]   err_tol_i,
  input  wire logic                        clear_i,
  output lgf_pkg::best_t                   best_o
);

  logic                        in_run_q, in_run_d, in_run_u;
  logic [lgf_pkg::TOL_W-1:0]   blocked_q, blocked_d, blocked_u;
  logic [lgf_pkg::IDX_W-1:0]   run_start_q, run_start_d, run_start_u;
  logic [lgf_pkg::SIZE_W-1:0]  run_size_q, run_size_d, run_size_u;
  lgf_pkg::best_t              best_q, best_d, best_u;
  logic [lgf_pkg::SIZE_W:0]    ext_sum;
  logic [lgf_pkg::SIZE_W-1:0]  ext_size;

  // Extended run size, saturating at the top of the size field.
  assign ext_sum  = {1'b0, run_size_q} + (lgf_pkg::SIZE_W+1)'(1)
                  + (lgf_pkg::SIZE_W+1)'(blocked_q);
  assign ext_size = (ext_sum > {1'b0, lgf_pkg::SIZE_MAX}) ? lgf_pkg::SIZE_MAX
                                                          : ext_sum[lgf_pkg::SIZE_W-1:0];

  // Run update for one beam inside the search window.
  always_comb begin
    in_run_u    = in_run_q;
    blocked_u   = blocked_q;
    run_start_u = run_start_q;
    run_size_u  = run_size_q;
    best_u      = best_q;
    if (en_i) begin
      if (open_i) begin
        if (in_run_q) begin
          run_size_u = ext_size;
          blocked_u  = '0;
          if (ext_size > best_q.size) begin
            best_u.size  = ext_size;
            best_u.start = run_start_q;
          end
        end else begin
          in_run_u    = 1'b1;
          run_start_u = idx_i;
          run_size_u  = lgf_pkg::SIZE_W'(1);
          blocked_u   = '0;
        end
      end else if (in_run_q) begin
        if (blocked_q < err_tol_i) begin
          blocked_u = blocked_q + lgf_pkg::TOL_W'(1);
        end else begin
          in_run_u = 1'b0;
        end
      end
    end
  end

  // The end of a scan clears all tracker state after reporting.
  always_comb begin
    if (clear_i) begin
      in_run_d    = 1'b0;
      blocked_d   = '0;
      run_start_d = '0;
      run_size_d  = '0;
      best_d      = '0;
    end else begin
      in_run_d    = in_run_u;
      blocked_d   = blocked_u;
      run_start_d = run_start_u;
      run_size_d  = run_size_u;
      best_d      = best_u;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q    <= 1'b0;
      blocked_q   <= '0;
      run_start_q <= '0;
      run_size_q  <= '0;
      best_q      <= '0;
    end else begin
      in_run_q    <= in_run_d;
      blocked_q   <= blocked_d;
      run_start_q <= run_start_d;
      run_size_q  <= run_size_d;
      best_q      <= best_d;
    end
  end

  assign best_o = best_u;

endmodule

`default_nettype wire

/* src/lidar_largest_gap_finder_core.sv */
// ----------------------------------------------------------------------------
// lidar_largest_gap_finder_core: largest-gap search over one lidar scan
// Tracks open runs against a far and a near threshold and reports one gap
// at the end of each scan.
// ----------------------------------------------------------------------------
// Result path: the result word of a scan passes the beam register, then the result
// register, after its last beam is accepted.
// Throughput: one beam per cycle; the beam register stalls only when a last
// beam meets a result that has not yet been taken.
// Reset: registers return to their defaults, the beam counter and both trackers
// clear, and no result is pending. Trackers also clear after every scan.
`default_nettype none

module lidar_largest_gap_finder_core #(
  parameter int unsigned MAX_BEAMS  = lgf_pkg::MAX_BEAMS_DEF,
  parameter int unsigned RANGE_BITS = lgf_pkg::RANGE_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lgf_beam_if.sink   beam_i,
  lgf_cfg_if.sink    cfg_i,
  lgf_gap_if.source  gap_o
);

  localparam int unsigned CNT_W = $clog2(MAX_BEAMS + 1);
  localparam int unsigned CMP_W = (CNT_W > lgf_pkg::IDX_W) ? CNT_W : lgf_pkg::IDX_W;
  localparam int unsigned RNG_W = (RANGE_BITS < lgf_pkg::RANGE_W) ? RANGE_BITS
                                                                   : lgf_pkg::RANGE_W;

  // Configuration registers.
  logic [lgf_pkg::RANGE_W-1:0] far_thr_q, near_thr_q;
  logic [lgf_pkg::TOL_W-1:0]   err_tol_q;
  logic [lgf_pkg::IDX_W-1:0]   first_q, last_q;
  logic [lgf_pkg::SIZE_W-1:0]  min_gap_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      far_thr_q  <= lgf_pkg::FAR_THR_RST;
      near_thr_q <= lgf_pkg::NEAR_THR_RST;
      err_tol_q  <= lgf_pkg::TOL_RST;
      first_q    <= lgf_pkg::FIRST_RST;
      last_q     <= lgf_pkg::LAST_RST;
      min_gap_q  <= lgf_pkg::MIN_GAP_RST;
    end else if (cfg_i.valid) begin
      case (lgf_pkg::reg_idx_e'(cfg_i.index))
        lgf_pkg::REG_FAR_THR:  far_thr_q  <= cfg_i.data;
        lgf_pkg::REG_NEAR_THR: near_thr_q <= cfg_i.data;
        lgf_pkg::REG_ERR_TOL:  err_tol_q  <= cfg_i.data[lgf_pkg::TOL_W-1:0];
        lgf_pkg::REG_FIRST:    first_q    <= cfg_i.data[lgf_pkg::IDX_W-1:0];
        lgf_pkg::REG_LAST:     last_q     <= cfg_i.data[lgf_pkg::IDX_W-1:0];
        lgf_pkg::REG_MIN_GAP:  min_gap_q  <= cfg_i.data[lgf_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Beam register and its handshake.
  logic                        in_vld_q;
  logic [lgf_pkg::RANGE_W-1:0] range_q;
  logic                        last_q_beam;
  logic                        proc_fire;
  logic                        out_free;
  logic                        in_fire;

  assign out_free     = !gap_o.valid || gap_o.ready;
  assign proc_fire    = in_vld_q && (!last_q_beam || out_free);
  assign beam_i.ready = !in_vld_q || proc_fire;
  assign in_fire      = beam_i.valid && beam_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (beam_i.ready) begin
      in_vld_q <= beam_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      range_q     <= beam_i.range_mm;
      last_q_beam <= beam_i.last_beam;
    end
  end

  // Beam counter, saturating at the beam capacity.
  logic [CNT_W-1:0] beam_q, beam_d;
  logic [CMP_W-1:0] beam_wide;
  logic             beam_live;
  logic             in_window;
  logic             trk_en;
  logic             scan_end;

  assign beam_wide = CMP_W'(beam_q);
  assign beam_live = beam_q < CNT_W'(MAX_BEAMS);
  assign in_window = (beam_wide >= CMP_W'(first_q)) && (beam_wide <= CMP_W'(last_q));
  assign trk_en    = proc_fire && beam_live && in_window;
  assign scan_end  = proc_fire && last_q_beam;

  always_comb begin
    beam_d = beam_q;
    if (scan_end) begin
      beam_d = '0;
    end else if (proc_fire && beam_live) begin
      beam_d = beam_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_q <= '0;
    end else begin
      beam_q <= beam_d;
    end
  end

  // Threshold compares on the low range bits.
  logic far_open, near_open;

  assign far_open  = range_q[RNG_W-1:0] > far_thr_q[RNG_W-1:0];
  assign near_open = range_q[RNG_W-1:0] > near_thr_q[RNG_W-1:0];

  // Far and near trackers.
  lgf_pkg::best_t far_best, near_best;

  lgf_tracker u_far (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (trk_en),
    .open_i    (far_open),
    .idx_i     (beam_wide[lgf_pkg::IDX_W-1:0]),
    .err_tol_i (err_tol_q),
    .clear_i   (scan_end),
    .best_o    (far_best)
  );

  lgf_tracker u_near (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (trk_en),
    .open_i    (near_open),
    .idx_i     (beam_wide[lgf_pkg::IDX_W-1:0]),
    .err_tol_i (err_tol_q),
    .clear_i   (scan_end),
    .best_o    (near_best)
  );

  // Gap choice: far gap first, near gap as fallback.
  logic [lgf_pkg::IDX_W-1:0]  sel_start;
  logic [lgf_pkg::SIZE_W-1:0] sel_size;
  logic                       sel_near, sel_found;

  always_comb begin
    sel_start = '0;
    sel_size  = '0;
    sel_near  = 1'b0;
    sel_found = 1'b0;
    if (far_best.size > min_gap_q) begin
      sel_start = far_best.start;
      sel_size  = far_best.size;
      sel_found = 1'b1;
    end else if (near_best.size > min_gap_q) begin
      sel_start = near_best.start;
      sel_size  = near_best.size;
      sel_near  = 1'b1;
      sel_found = 1'b1;
    end
  end

  // Result register.
  logic                       out_vld_q, out_vld_d;
  logic [lgf_pkg::IDX_W-1:0]  start_q;
  logic [lgf_pkg::SIZE_W-1:0] size_q;
  logic                       near_q, found_q;

  always_comb begin
    out_vld_d = out_vld_q;
    if (scan_end) begin
      out_vld_d = 1'b1;
    end else if (gap_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_end) begin
      start_q <= sel_start;
      size_q  <= sel_size;
      near_q  <= sel_near;
      found_q <= sel_found;
    end
  end

  assign gap_o.valid     = out_vld_q;
  assign gap_o.gap_start = start_q;
  assign gap_o.gap_size  = size_q;
  assign gap_o.used_near = near_q;
  assign gap_o.gap_found = found_q;

endmodule

`default_nettype wire

/* tb/sv/tb_lidar_largest_gap_finder_core.sv */
// ----------------------------------------------------------------------------
// tb_lidar_largest_gap_finder_core: self-checking bench for the gap finder
// Streams lidar scans into the core, predicts the far/near gap of every scan
// with a behavioral tracker model and checks each gap word in order.
// ----------------------------------------------------------------------------

module tb_lidar_largest_gap_finder_core;

  localparam int unsigned CYCLE_LIMIT      = 500000;
  localparam int unsigned SETTLE_CYCLES    = 6;
  localparam int unsigned RANDOM_BEAMS     = 870;
  localparam int unsigned MIN_RANDOM_SCANS = 8;
  localparam int          FAR_TRK          = 0;
  localparam int          NEAR_TRK         = 1;

  // Register indexes past the end of the map; writes to them must be dropped.
  localparam logic [lgf_pkg::REG_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [lgf_pkg::REG_W-1:0] REG_SPARE_HI = 3'd7;

  // Flavors of beam segments used to build scans.
  typedef enum int {
    SEG_FAR_OPEN,
    SEG_NEAR_OPEN,
    SEG_BLOCKED,
    SEG_EDGE,
    SEG_NOISE
  } seg_kind_e;

  typedef struct packed {
    logic [lgf_pkg::RANGE_W-1:0] range_mm;
    logic                        last_beam;
  } beam_t;

  typedef struct packed {
    logic [lgf_pkg::IDX_W-1:0]  gap_start;
    logic [lgf_pkg::SIZE_W-1:0] gap_size;
    logic                       used_near;
    logic                       gap_found;
  } gap_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lgf_beam_if beam_ch ();
  lgf_gap_if  gap_ch ();
  lgf_cfg_if  cfg_ch ();

  lidar_largest_gap_finder_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beam_i (beam_ch),
    .cfg_i  (cfg_ch),
    .gap_o  (gap_ch)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the register file.
  logic [lgf_pkg::RANGE_W-1:0] far_thr;
  logic [lgf_pkg::RANGE_W-1:0] near_thr;
  logic [lgf_pkg::TOL_W-1:0]   err_tol;
  logic [lgf_pkg::IDX_W-1:0]   win_first;
  logic [lgf_pkg::IDX_W-1:0]   win_last;
  logic [lgf_pkg::SIZE_W-1:0]  min_gap;

  // Shadow copy of the scan state; index 0 is the far tracker, 1 the near one.
  int unsigned                 beam_cnt;
  bit                          in_run     [2];
  logic [lgf_pkg::TOL_W-1:0]   blocked    [2];
  logic [lgf_pkg::IDX_W-1:0]   run_start  [2];
  logic [lgf_pkg::SIZE_W-1:0]  run_size   [2];
  logic [lgf_pkg::IDX_W-1:0]   best_start [2];
  logic [lgf_pkg::SIZE_W-1:0]  best_size  [2];

  beam_t       pending_beams_q[$];
  gap_t        predicted_gaps_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  // Handshake flags, set at the rising edge and read at the falling edge.
  bit          beam_acc = 1'b0;
  bit          gap_acc  = 1'b0;
  bit          beam_busy = 1'b0;
  int unsigned beam_hold = 0;
  int unsigned gap_stall = 0;
  bit          beam_idle_on = 1'b1;
  bit          gap_idle_on  = 1'b1;

  // Clear both trackers and the beam counter at the end of a scan.
  function void clear_scan_state();
    beam_cnt = 0;
    for (int t = 0; t < 2; t++) begin
      in_run[t]     = 1'b0;
      blocked[t]    = '0;
      run_start[t]  = '0;
      run_size[t]   = '0;
      best_start[t] = '0;
      best_size[t]  = '0;
    end
  endfunction

  // One tracker step. The best gap is only updated when a run is extended.
  function void track_run(int t, bit open, logic [lgf_pkg::IDX_W-1:0] idx);
    int unsigned grown;
    if (open) begin
      if (in_run[t]) begin
        grown = run_size[t] + 1 + blocked[t];
        run_size[t] = (grown > lgf_pkg::SIZE_MAX) ? lgf_pkg::SIZE_MAX
                                                  : grown[lgf_pkg::SIZE_W-1:0];
        blocked[t] = '0;
        if (run_size[t] > best_size[t]) begin
          best_size[t]  = run_size[t];
          best_start[t] = run_start[t];
        end
      end else begin
        in_run[t]    = 1'b1;
        run_start[t] = idx;
        run_size[t]  = lgf_pkg::SIZE_W'(1);
        blocked[t]   = '0;
      end
    end else if (in_run[t]) begin
      if (blocked[t] < err_tol) blocked[t] = blocked[t] + 1'b1;
      else in_run[t] = 1'b0;
    end
  endfunction

  // Advance the scan by one beam; a last beam yields the chosen gap.
  function void gap_search_step(beam_t b, output bit has_gap, output gap_t g);
    has_gap = 1'b0;
    g       = '0;
    if (beam_cnt < lgf_pkg::MAX_BEAMS_DEF) begin
      if (beam_cnt >= win_first && beam_cnt <= win_last) begin
        track_run(FAR_TRK, b.range_mm > far_thr, beam_cnt[lgf_pkg::IDX_W-1:0]);
        track_run(NEAR_TRK, b.range_mm > near_thr, beam_cnt[lgf_pkg::IDX_W-1:0]);
      end
      beam_cnt++;
    end
    if (b.last_beam) begin
      has_gap = 1'b1;
      if (best_size[FAR_TRK] > min_gap) begin
        g.gap_start = best_start[FAR_TRK];
        g.gap_size  = best_size[FAR_TRK];
        g.gap_found = 1'b1;
      end else if (best_size[NEAR_TRK] > min_gap) begin
        g.gap_start = best_start[NEAR_TRK];
        g.gap_size  = best_size[NEAR_TRK];
        g.used_near = 1'b1;
        g.gap_found = 1'b1;
      end
      clear_scan_state();
    end
  endfunction

  task report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  // Cycle counter and watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAILURE");
      $finish;
    end
  end

  // Monitor: predict on every accepted beam word, check every gap word.
  always @(posedge clk_i) begin
    beam_t seen;
    gap_t  want;
    bit    has_gap;
    beam_acc = 1'b0;
    gap_acc  = 1'b0;
    if (rst_ni) begin
      if (beam_ch.valid && beam_ch.ready) begin
        beam_acc      = 1'b1;
        seen.range_mm  = beam_ch.range_mm;
        seen.last_beam = beam_ch.last_beam;
        gap_search_step(seen, has_gap, want);
        if (has_gap) predicted_gaps_q.push_back(want);
      end
      if (gap_ch.valid && gap_ch.ready) begin
        gap_acc = 1'b1;
        if (predicted_gaps_q.size() == 0) begin
          report_mismatch("gap word with none predicted, gap_size", gap_ch.gap_size, 0);
        end else begin
          want = predicted_gaps_q.pop_front();
          if (gap_ch.gap_start !== want.gap_start)
            report_mismatch("gap_start", gap_ch.gap_start, want.gap_start);
          if (gap_ch.gap_size !== want.gap_size)
            report_mismatch("gap_size", gap_ch.gap_size, want.gap_size);
          if (gap_ch.used_near !== want.used_near)
            report_mismatch("used_near", gap_ch.used_near, want.used_near);
          if (gap_ch.gap_found !== want.gap_found)
            report_mismatch("gap_found", gap_ch.gap_found, want.gap_found);
        end
      end
    end
  end

  // Beam driver: presents pending words, with a random wait after each one.
  always @(negedge clk_i) begin
    beam_t nxt;
    if (rst_ni) begin
      if (beam_busy && beam_acc) beam_busy = 1'b0;
      if (!beam_busy) begin
        if (beam_hold > 0) begin
          beam_hold--;
        end else if (pending_beams_q.size() != 0) begin
          nxt = pending_beams_q.pop_front();
          beam_ch.range_mm  <= nxt.range_mm;
          beam_ch.last_beam <= nxt.last_beam;
          beam_busy = 1'b1;
          beam_hold = beam_idle_on ? $urandom_range(0, 15) : 0;
        end
      end
      beam_ch.valid <= beam_busy;
    end
  end

  // Gap receiver: stalls a random number of cycles after each word.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (gap_acc) gap_stall = gap_idle_on ? $urandom_range(0, 15) : 0;
      if (gap_stall > 0) begin
        gap_stall--;
        gap_ch.ready <= 1'b0;
      end else begin
        gap_ch.ready <= 1'b1;
      end
    end
  end

  // Register value with random junk above the field width.
  function automatic logic [lgf_pkg::CFG_W-1:0] with_junk(int unsigned v, int unsigned w);
    logic [31:0] mask;
    mask = (32'h1 << w) - 1;
    return lgf_pkg::CFG_W'((v & mask) | ($urandom << w));
  endfunction

  task automatic write_reg(logic [lgf_pkg::REG_W-1:0] idx, logic [lgf_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      lgf_pkg::REG_FAR_THR:  far_thr   = data;
      lgf_pkg::REG_NEAR_THR: near_thr  = data;
      lgf_pkg::REG_ERR_TOL:  err_tol   = data[lgf_pkg::TOL_W-1:0];
      lgf_pkg::REG_FIRST:    win_first = data[lgf_pkg::IDX_W-1:0];
      lgf_pkg::REG_LAST:     win_last  = data[lgf_pkg::IDX_W-1:0];
      lgf_pkg::REG_MIN_GAP:  min_gap   = data[lgf_pkg::SIZE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic program_regs(int unsigned far_v, int unsigned near_v, int unsigned tol_v,
                              int unsigned first_v, int unsigned last_v, int unsigned gap_v);
    write_reg(lgf_pkg::REG_FAR_THR, with_junk(far_v, lgf_pkg::RANGE_W));
    write_reg(lgf_pkg::REG_NEAR_THR, with_junk(near_v, lgf_pkg::RANGE_W));
    write_reg(lgf_pkg::REG_ERR_TOL, with_junk(tol_v, lgf_pkg::TOL_W));
    write_reg(lgf_pkg::REG_FIRST, with_junk(first_v, lgf_pkg::IDX_W));
    write_reg(lgf_pkg::REG_LAST, with_junk(last_v, lgf_pkg::IDX_W));
    write_reg(lgf_pkg::REG_MIN_GAP, with_junk(gap_v, lgf_pkg::SIZE_W));
  endtask

  task automatic push_beam(int unsigned range_v, bit last_v);
    beam_t b;
    b.range_mm  = range_v[lgf_pkg::RANGE_W-1:0];
    b.last_beam = last_v;
    pending_beams_q.push_back(b);
  endtask

  // Pick a range that lands on the chosen side of the thresholds.
  function automatic int unsigned pick_range(seg_kind_e kind);
    int unsigned lo;
    case (kind)
      SEG_FAR_OPEN:
        return (far_thr == 16'hFFFF) ? 16'hFFFF : $urandom_range(far_thr + 1, 16'hFFFF);
      SEG_NEAR_OPEN:
        return (near_thr < far_thr) ? $urandom_range(near_thr + 1, far_thr)
                                    : $urandom_range(0, 16'hFFFF);
      SEG_BLOCKED: begin
        lo = (near_thr < far_thr) ? near_thr : far_thr;
        return $urandom_range(0, lo);
      end
      SEG_EDGE:
        case ($urandom_range(0, 3))
          0: return far_thr;
          1: return (far_thr + 1) & 16'hFFFF;
          2: return near_thr;
          default: return (near_thr + 1) & 16'hFFFF;
        endcase
      default:
        return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // Queue one scan of n beams, built from segments of like beams.
  task automatic push_scan(int unsigned n);
    seg_kind_e   kind;
    int unsigned seg_len;
    int unsigned i;
    i = 0;
    while (i < n) begin
      kind = seg_kind_e'($urandom_range(0, 4));
      if (kind == SEG_BLOCKED) seg_len = $urandom_range(1, (err_tol > 18) ? 20 : err_tol + 2);
      else seg_len = $urandom_range(1, 12);
      for (int j = 0; j < seg_len && i < n; j++) begin
        push_beam(pick_range(kind), i == n - 1);
        i++;
      end
    end
  endtask

  // Hold the sender until every predicted gap word has been taken.
  task automatic drain_results();
    while (pending_beams_q.size() != 0 || beam_busy || predicted_gaps_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_config();
    int unsigned far_v, near_v, tol_v, first_v, last_v, gap_v;
    case ($urandom_range(0, 7))
      0:       far_v = 0;
      1:       far_v = 16'hFFFF;
      default: far_v = $urandom_range(0, 16'hFFFF);
    endcase
    case ($urandom_range(0, 7))
      0:       near_v = 0;
      1:       near_v = 16'hFFFF;
      2:       near_v = $urandom_range(0, 16'hFFFF);
      default: near_v = $urandom_range(0, far_v);
    endcase
    tol_v   = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 10);
    first_v = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 40);
    case ($urandom_range(0, 9))
      0:       last_v = 2047;
      1:       last_v = (first_v == 0) ? 0 : $urandom_range(0, first_v - 1);
      default: last_v = first_v + $urandom_range(5, 80);
    endcase
    case ($urandom_range(0, 11))
      0:       gap_v = 2048;
      1:       gap_v = 4095;
      2:       gap_v = 0;
      default: gap_v = $urandom_range(0, 25);
    endcase
    program_regs(far_v, near_v, tol_v, first_v, last_v, gap_v);
  endtask

  initial begin
    int unsigned rand_beams;
    int unsigned rand_scans;
    int unsigned n;
    int unsigned n_scans;
    int unsigned span;

    beam_ch.valid     = 1'b0;
    beam_ch.range_mm  = '0;
    beam_ch.last_beam = 1'b0;
    gap_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;

    far_thr   = lgf_pkg::FAR_THR_RST;
    near_thr  = lgf_pkg::NEAR_THR_RST;
    err_tol   = lgf_pkg::TOL_RST;
    win_first = lgf_pkg::FIRST_RST;
    win_last  = lgf_pkg::LAST_RST;
    min_gap   = lgf_pkg::MIN_GAP_RST;
    clear_scan_state();

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: a short scan ending before the window finds nothing.
    push_beam(16'hFFFF, 1'b0);
    push_beam(16'h0000, 1'b0);
    push_beam(16'hFFFF, 1'b1);
    drain_results();

    // Small window with bridging of one blocked beam and exact threshold hits.
    program_regs(100, 50, 1, 2, 12, 3);
    push_beam(0, 1'b0);
    push_beam(16'hFFFF, 1'b0);
    push_beam(16'hFFFF, 1'b0);
    push_beam(60, 1'b0);
    push_beam(16'hFFFF, 1'b0);
    push_beam(100, 1'b0);
    push_beam(101, 1'b0);
    push_beam(50, 1'b0);
    push_beam(0, 1'b0);
    push_beam(51, 1'b0);
    push_beam(16'hFFFF, 1'b0);
    push_beam(16'hFFFF, 1'b1);
    drain_results();

    // Writes past the register map are dropped; then an empty window.
    write_reg(REG_SPARE_LO, lgf_pkg::CFG_W'($urandom_range(0, 16'hFFFF)));
    write_reg(REG_SPARE_HI, lgf_pkg::CFG_W'($urandom_range(0, 16'hFFFF)));
    program_regs(0, 0, 0, 10, 5, 0);
    repeat (11) push_beam(16'hFFFF, 1'b0);
    push_beam(16'hFFFF, 1'b1);
    drain_results();

    // A run of one beam never becomes the best; two beams do.
    program_regs(0, 16'hFFFF, 0, 0, 2047, 0);
    push_beam(16'hFFFF, 1'b0);
    push_beam(0, 1'b1);
    push_beam(16'hFFFF, 1'b0);
    push_beam(16'hFFFF, 1'b1);
    drain_results();

    // Random phases, each with its own settings and idling mix.
    rand_beams = 0;
    rand_scans = 0;
    while (rand_beams < RANDOM_BEAMS || rand_scans < MIN_RANDOM_SCANS) begin
      random_config();
      beam_idle_on = ($urandom_range(0, 3) != 0);
      gap_idle_on  = ($urandom_range(0, 3) != 0);
      n_scans = $urandom_range(1, 4);
      for (int unsigned s = 0;
           s < n_scans && (rand_beams < RANDOM_BEAMS || rand_scans < MIN_RANDOM_SCANS);
           s++) begin
        span = (win_last >= win_first) ? win_last - win_first : 0;
        if (span > 150) span = 150;
        if ($urandom_range(0, 5) == 0) n = $urandom_range(1, 10);
        else n = win_first + $urandom_range(1, span + 10);
        push_scan(n);
        rand_beams += n;
        rand_scans++;
      end
      drain_results();
    end

    if (predicted_gaps_q.size() != 0)
      report_mismatch("gap words never delivered", 0, predicted_gaps_q.size());
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
